### sv/local_map_box_shifter_core_assert.svh
// ----------------------------------------------------------------------------
// Local map box shifter assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MAP_BOX_SHIFTER_CORE_ASSERT_SVH
`define LOCAL_MAP_BOX_SHIFTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LMBS_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define LMBS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### sv/lmbs_pkg.sv
// ----------------------------------------------------------------------------
// Local map box shifter package
// Payload types, result kinds, register indexes and shared helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmbs_pkg;

	localparam int AXES       = 3;
	localparam int COORD_W    = 32;
	localparam int CUBE_W     = 24;
	localparam int DET_W      = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int STEP_W     = 28;
	localparam int MOV_W      = 23;
	localparam int MAX_RES    = 4;
	localparam int RES_IDX_W  = 2;
	localparam int RES_CNT_W  = 3;

	localparam logic [CUBE_W-1:0] CUBE_RESET = 24'd256000;
	localparam logic [DET_W-1:0]  DET_RESET  = 22'd25600;

	// floor(t / 5) = (t * DIV5_MAGIC) >> DIV5_SHIFT for any 32-bit t.
	localparam logic [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;
	localparam int          DIV5_SHIFT = 34;

	localparam logic [1:0] CFG_SETTLE = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUBE_SIDE    = 2'd0,
		CFG_DETECT_RANGE = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_PLACED = 2'd0,
		KIND_KEEP   = 2'd1,
		KIND_MOVED  = 2'd2,
		KIND_SLAB   = 2'd3
	} kind_t;

	typedef logic [AXES-1:0][COORD_W-1:0] vec3_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} pos_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] lo_y;
		logic signed [COORD_W-1:0] lo_z;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] hi_y;
		logic signed [COORD_W-1:0] hi_z;
		logic                      last;
	} res_t;

	// Saturate a 35-bit signed value to the signed 32-bit range.
	function automatic logic [COORD_W-1:0] sat32(input logic signed [34:0] v);
		logic ovf;
		ovf = (v[34:31] != 4'b0000) && (v[34:31] != 4'b1111);
		if (!ovf) begin
			return v[COORD_W-1:0];
		end else if (v[34]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7FFF_FFFF;
		end
	endfunction

	function automatic res_t pack_res(input kind_t k, input vec3_t lo, input vec3_t hi,
			input logic last);
		res_t r;
		r.kind = k;
		r.lo_x = lo[0];
		r.lo_y = lo[1];
		r.lo_z = lo[2];
		r.hi_x = hi[0];
		r.hi_y = hi[1];
		r.hi_z = hi[2];
		r.last = last;
		return r;
	endfunction

endpackage

### sv/local_map_box_shifter_core.sv
// An accepted position is held in pos_s1, then its results load once the output is free.
// Throughput: one result per unstalled cycle; a position yields one to four results.
// Single-result positions are accepted in every cycle unless res_stall or settling holds.
// A configuration write stalls input while the step size is recomputed.
// Reset: config registers return to defaults; the box is cleared and marked not placed.
// ----------------------------------------------------------------------------
// Local map box shifter core
// Keeps a local map box around the sensor position, shifts it when the sensor
// approaches a face and reports removal slabs followed by the resulting box.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_map_box_shifter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lmbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lmbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                pos_valid,
	output logic                                pos_stall,
	input  lmbs_pkg::pos_t                      pos,
	output logic                                res_valid,
	input  logic                                res_stall,
	output lmbs_pkg::res_t                      res
);

	logic [lmbs_pkg::CUBE_W-1:0]    cube_q;
	logic [lmbs_pkg::DET_W-1:0]     det_q;
	logic [1:0]                     settle_q;
	logic [lmbs_pkg::STEP_W-1:0]    step_q;
	logic [lmbs_pkg::MOV_W-1:0]     mov_q;

	logic                           valid_s1;
	lmbs_pkg::pos_t                 pos_s1;

	lmbs_pkg::vec3_t                box_lo_q;
	lmbs_pkg::vec3_t                box_hi_q;
	logic                           placed_q;

	lmbs_pkg::res_t                 res_q [lmbs_pkg::MAX_RES];
	logic [lmbs_pkg::RES_CNT_W-1:0] cnt_q;
	logic [lmbs_pkg::RES_IDX_W-1:0] ptr_q;

	logic [23:0]                    thr3;
	logic signed [25:0]             diff;
	logic signed [29:0]             step_a;
	logic [25:0]                    step_b;
	logic [lmbs_pkg::STEP_W-1:0]    step_d;
	logic [57:0]                    mov_prod;

	lmbs_pkg::res_t                 ent [lmbs_pkg::MAX_RES];
	logic [lmbs_pkg::RES_CNT_W-1:0] ent_cnt;
	lmbs_pkg::vec3_t                nxt_lo;
	lmbs_pkg::vec3_t                nxt_hi;

	logic                           res_fire;
	logic                           load;

	// Step size: max(9 * (cube - 3 * det), 10 * det) / 20, over two registers.
	always_comb begin
		thr3     = {1'b0, det_q, 1'b0} + {2'b00, det_q};
		diff     = $signed({2'b00, cube_q}) - $signed({2'b00, thr3});
		step_a   = ($signed(30'(diff)) <<< 3) + $signed(30'(diff));
		step_b   = {1'b0, det_q, 3'b000} + {3'b000, det_q, 1'b0};
		step_d   = (step_a > $signed({4'b0000, step_b})) ? step_a[lmbs_pkg::STEP_W-1:0]
			: {2'b00, step_b};
		mov_prod = 58'(step_q[lmbs_pkg::STEP_W-1:2]) * 58'(lmbs_pkg::DIV5_MAGIC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cube_q   <= lmbs_pkg::CUBE_RESET;
			det_q    <= lmbs_pkg::DET_RESET;
			settle_q <= lmbs_pkg::CFG_SETTLE;
		end else begin
			if (cfg_we) begin
				settle_q <= lmbs_pkg::CFG_SETTLE;
				case (lmbs_pkg::cfg_idx_t'(cfg_index))
					lmbs_pkg::CFG_CUBE_SIDE: begin
						cube_q <= cfg_data;
					end
					lmbs_pkg::CFG_DETECT_RANGE: begin
						det_q <= cfg_data[lmbs_pkg::DET_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		step_q <= step_d;
		mov_q  <= mov_prod[lmbs_pkg::DIV5_SHIFT +: lmbs_pkg::MOV_W];
	end

	assign res       = res_q[ptr_q];
	assign res_valid = (cnt_q != '0);
	assign res_fire  = res_valid && !res_stall;
	assign load      = valid_s1 && (!res_valid || (res_fire && res.last));
	assign pos_stall = (settle_q != 2'd0) || (valid_s1 && !load);

	always_comb begin
		lmbs_pkg::vec3_t        p;
		lmbs_pkg::vec3_t        plc_lo;
		lmbs_pkg::vec3_t        plc_hi;
		lmbs_pkg::vec3_t        dn_lo;
		lmbs_pkg::vec3_t        dn_hi;
		lmbs_pkg::vec3_t        up_lo;
		lmbs_pkg::vec3_t        up_hi;
		lmbs_pkg::vec3_t        mv_lo;
		lmbs_pkg::vec3_t        mv_hi;
		lmbs_pkg::vec3_t        sl_lo;
		lmbs_pkg::vec3_t        sl_hi;
		logic [2:0]             near_lo;
		logic [2:0]             near_hi;
		logic signed [34:0]     thr_s;
		logic signed [34:0]     lo_w;
		logic signed [34:0]     dl2;
		logic signed [34:0]     dh2;
		logic signed [34:0]     mov_s;
		logic [1:0]             n;
		p[0]    = pos_s1.pos_x;
		p[1]    = pos_s1.pos_y;
		p[2]    = pos_s1.pos_z;
		thr_s   = $signed({11'd0, thr3});
		mov_s   = $signed({12'd0, mov_q});
		for (int i = 0; i < lmbs_pkg::AXES; i++) begin
			lo_w       = 35'($signed(p[i])) - $signed({12'd0, cube_q[lmbs_pkg::CUBE_W-1:1]});
			plc_lo[i]  = lmbs_pkg::sat32(lo_w);
			plc_hi[i]  = lmbs_pkg::sat32(lo_w + $signed({11'd0, cube_q}));
			dl2        = (35'($signed(p[i])) - 35'($signed(box_lo_q[i]))) <<< 1;
			dh2        = (35'($signed(p[i])) - 35'($signed(box_hi_q[i]))) <<< 1;
			near_lo[i] = (dl2 <= thr_s) && (dl2 >= -thr_s);
			near_hi[i] = (dh2 <= thr_s) && (dh2 >= -thr_s);
			dn_lo[i]   = lmbs_pkg::sat32(35'($signed(box_lo_q[i])) - mov_s);
			dn_hi[i]   = lmbs_pkg::sat32(35'($signed(box_hi_q[i])) - mov_s);
			up_lo[i]   = lmbs_pkg::sat32(35'($signed(box_lo_q[i])) + mov_s);
			up_hi[i]   = lmbs_pkg::sat32(35'($signed(box_hi_q[i])) + mov_s);
		end

		mv_lo = box_lo_q;
		mv_hi = box_hi_q;
		for (int i = 0; i < lmbs_pkg::AXES; i++) begin
			if (near_lo[i]) begin
				mv_lo[i] = dn_lo[i];
				mv_hi[i] = dn_hi[i];
			end else if (near_hi[i]) begin
				mv_lo[i] = up_lo[i];
				mv_hi[i] = up_hi[i];
			end
		end

		for (int k = 0; k < lmbs_pkg::MAX_RES; k++) begin
			ent[k] = '0;
		end
		n = 2'd0;
		for (int i = 0; i < lmbs_pkg::AXES; i++) begin
			sl_lo = box_lo_q;
			sl_hi = box_hi_q;
			if (near_lo[i]) begin
				sl_lo[i] = dn_hi[i];
			end else begin
				sl_hi[i] = up_lo[i];
			end
			if (near_lo[i] || near_hi[i]) begin
				ent[n] = lmbs_pkg::pack_res(lmbs_pkg::KIND_SLAB, sl_lo, sl_hi, 1'b0);
				n      = n + 2'd1;
			end
		end

		if (!placed_q) begin
			nxt_lo  = plc_lo;
			nxt_hi  = plc_hi;
			ent[0]  = lmbs_pkg::pack_res(lmbs_pkg::KIND_PLACED, plc_lo, plc_hi, 1'b1);
			ent_cnt = 3'd1;
		end else if ((near_lo | near_hi) == 3'b000) begin
			nxt_lo  = box_lo_q;
			nxt_hi  = box_hi_q;
			ent[0]  = lmbs_pkg::pack_res(lmbs_pkg::KIND_KEEP, box_lo_q, box_hi_q, 1'b1);
			ent_cnt = 3'd1;
		end else begin
			nxt_lo  = mv_lo;
			nxt_hi  = mv_hi;
			ent[n]  = lmbs_pkg::pack_res(lmbs_pkg::KIND_MOVED, mv_lo, mv_hi, 1'b1);
			ent_cnt = {1'b0, n} + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			placed_q <= 1'b0;
			box_lo_q <= '0;
			box_hi_q <= '0;
			cnt_q    <= '0;
			ptr_q    <= '0;
		end else begin
			if (!pos_stall) begin
				valid_s1 <= pos_valid;
			end
			if (load) begin
				placed_q <= 1'b1;
				box_lo_q <= nxt_lo;
				box_hi_q <= nxt_hi;
				cnt_q    <= ent_cnt;
				ptr_q    <= '0;
			end else if (res_fire && res.last) begin
				cnt_q <= '0;
				ptr_q <= '0;
			end else if (res_fire) begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pos_valid && !pos_stall) begin
			pos_s1 <= pos;
		end
		if (load) begin
			for (int k = 0; k < lmbs_pkg::MAX_RES; k++) begin
				res_q[k] <= ent[k];
			end
		end
	end

endmodule

### sv/lmbs_chk.sv
// ----------------------------------------------------------------------------
// Local map box shifter port checker
// Watches the result channel of the core and is attached to it by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "local_map_box_shifter_core_assert.svh"

module lmbs_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input lmbs_pkg::res_t res
);

	`LMBS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result transaction changed")
	`LMBS_ASSERT_NEXT(a_slab_follow, res_valid && !res_stall && !res.last, res_valid, "no result after a removal slab")
	`LMBS_ASSERT_NOW(a_last_kind, res_valid, res.last == (res.kind != lmbs_pkg::KIND_SLAB), "last flag does not match result kind")
	`LMBS_ASSERT_NOW(a_box_order, res_valid, (res.lo_x <= res.hi_x) && (res.lo_y <= res.hi_y) && (res.lo_z <= res.hi_z), "lower corner above upper corner")

endmodule

bind local_map_box_shifter_core lmbs_chk u_lmbs_chk (.*);

### sim/local_map_box_shifter_core_test.sv
// ----------------------------------------------------------------------------
// Local map box shifter core testbench
// Sends sensor positions aimed at and around the faces of the current box,
// and at the coordinate extremes. It runs through several cube and range
// settings under random sender and receiver idling and one long receiver
// hold-off. A box tracker computes every removal slab and box that should
// come out, and each result transaction is compared with it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_map_box_shifter_core_test;

	import lmbs_pkg::*;

	localparam longint COORD_MAX = 64'sh7FFF_FFFF;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;
	localparam int PHASES = 7;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 10;
	localparam int LONG_HOLD = 200;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef longint corner_t [AXES];

	typedef enum int {
		AIM_CENTER,
		AIM_LO_NEAR,
		AIM_HI_NEAR,
		AIM_LO_EDGE,
		AIM_LO_FAR,
		AIM_HI_EDGE,
		AIM_HI_FAR,
		AIM_ANY,
		AIM_MIN,
		AIM_MAX
	} aim_t;

	function automatic longint clip32(longint v);
		if (v > COORD_MAX) begin
			return COORD_MAX;
		end
		if (v < COORD_MIN) begin
			return COORD_MIN;
		end
		return v;
	endfunction

	class box_scoreboard;
		logic [CUBE_W-1:0] cube_side;
		logic [DET_W-1:0]  detect_range;
		corner_t           box_lo;
		corner_t           box_hi;
		bit                placed;
		res_t              expected_q [$];
		int errors, positions, results, writes;
		int placed_cnt, keep_cnt, moved_cnt, slab_cnt;

		function new();
			cube_side = CUBE_RESET;
			detect_range = DET_RESET;
			placed = 1'b0;
			foreach (box_lo[i]) begin
				box_lo[i] = 0;
				box_hi[i] = 0;
			end
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			writes++;
			case (idx)
				CFG_CUBE_SIDE: begin
					cube_side = data[CUBE_W-1:0];
				end
				CFG_DETECT_RANGE: begin
					detect_range = data[DET_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function longint reach();
			return (3 * longint'(detect_range)) / 2;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void expect_box(kind_t k, corner_t lo, corner_t hi, logic last);
			res_t r;
			r.kind = k;
			r.lo_x = lo[0][COORD_W-1:0];
			r.lo_y = lo[1][COORD_W-1:0];
			r.lo_z = lo[2][COORD_W-1:0];
			r.hi_x = hi[0][COORD_W-1:0];
			r.hi_y = hi[1][COORD_W-1:0];
			r.hi_z = hi[2][COORD_W-1:0];
			r.last = last;
			results++;
			expected_q = {expected_q, r};
		endfunction

		function void note_position(pos_t p);
			corner_t at, new_lo, new_hi, slab_lo, slab_hi;
			bit near_lo [AXES];
			bit near_hi [AXES];
			bit any_near;
			longint cube, det, dl, dh, step_a, step_b, shift;
			at[0] = longint'(p.pos_x);
			at[1] = longint'(p.pos_y);
			at[2] = longint'(p.pos_z);
			cube = longint'(cube_side);
			det = longint'(detect_range);
			positions++;
			if (!placed) begin
				for (int i = 0; i < AXES; i++) begin
					box_lo[i] = clip32(at[i] - cube / 2);
					box_hi[i] = clip32(at[i] - cube / 2 + cube);
				end
				placed = 1'b1;
				placed_cnt++;
				expect_box(KIND_PLACED, box_lo, box_hi, 1'b1);
				return;
			end
			any_near = 1'b0;
			for (int i = 0; i < AXES; i++) begin
				dl = at[i] - box_lo[i];
				dh = at[i] - box_hi[i];
				if (dl < 0) begin
					dl = -dl;
				end
				if (dh < 0) begin
					dh = -dh;
				end
				near_lo[i] = (2 * dl <= 3 * det);
				near_hi[i] = (2 * dh <= 3 * det);
				any_near |= near_lo[i] | near_hi[i];
			end
			if (!any_near) begin
				keep_cnt++;
				expect_box(KIND_KEEP, box_lo, box_hi, 1'b1);
				return;
			end
			step_a = 9 * (cube - 3 * det);
			step_b = 10 * det;
			shift = ((step_a > step_b) ? step_a : step_b) / 20;
			new_lo = box_lo;
			new_hi = box_hi;
			for (int i = 0; i < AXES; i++) begin
				slab_lo = box_lo;
				slab_hi = box_hi;
				if (near_lo[i]) begin
					new_lo[i] = clip32(box_lo[i] - shift);
					new_hi[i] = clip32(box_hi[i] - shift);
					slab_lo[i] = clip32(box_hi[i] - shift);
				end else if (near_hi[i]) begin
					new_lo[i] = clip32(box_lo[i] + shift);
					new_hi[i] = clip32(box_hi[i] + shift);
					slab_hi[i] = clip32(box_lo[i] + shift);
				end else begin
					continue;
				end
				slab_cnt++;
				expect_box(KIND_SLAB, slab_lo, slab_hi, 1'b0);
			end
			box_lo = new_lo;
			box_hi = new_hi;
			moved_cnt++;
			expect_box(KIND_MOVED, box_lo, box_hi, 1'b1);
		endfunction

		function void compare_field(string label, logic signed [32:0] want,
				logic signed [32:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, kind %0d lo (%0d,%0d,%0d) hi (%0d,%0d,%0d) last %0d",
					$time, got.kind, got.lo_x, got.lo_y, got.lo_z, got.hi_x, got.hi_y,
					got.hi_z, got.last);
				return;
			end
			want = expected_q.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("lo_x", want.lo_x, got.lo_x);
			compare_field("lo_y", want.lo_y, got.lo_y);
			compare_field("lo_z", want.lo_z, got.lo_z);
			compare_field("hi_x", want.hi_x, got.hi_x);
			compare_field("hi_y", want.hi_y, got.hi_y);
			compare_field("hi_z", want.hi_z, got.hi_z);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pos_valid;
	logic                  pos_stall;
	pos_t                  pos;
	logic                  res_valid;
	logic                  res_stall;
	res_t                  res;

	box_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int quiet_cycles = 0;

	local_map_box_shifter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pos_valid (pos_valid),
		.pos_stall (pos_stall),
		.pos       (pos),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [COORD_W-1:0] aim_coord(aim_t aim, longint lo, longint hi,
			longint t);
		longint v, sgn;
		sgn = ($urandom_range(1) != 0) ? 1 : -1;
		case (aim)
			AIM_CENTER:  v = lo + (hi - lo) / 2 + longint'($urandom_range(64)) - 32;
			AIM_LO_NEAR: v = lo + longint'($urandom_range(32'(2 * t + 4))) - t - 2;
			AIM_HI_NEAR: v = hi + longint'($urandom_range(32'(2 * t + 4))) - t - 2;
			AIM_LO_EDGE: v = lo + sgn * t;
			AIM_LO_FAR:  v = lo + sgn * (t + 1);
			AIM_HI_EDGE: v = hi + sgn * t;
			AIM_HI_FAR:  v = hi + sgn * (t + 1);
			AIM_MIN:     v = COORD_MIN;
			AIM_MAX:     v = COORD_MAX;
			default:     return $urandom();
		endcase
		return COORD_W'(clip32(v));
	endfunction

	function automatic aim_t random_aim();
		int r;
		r = $urandom_range(99);
		if (r < 22) return AIM_LO_NEAR;
		if (r < 44) return AIM_HI_NEAR;
		if (r < 48) return AIM_LO_EDGE;
		if (r < 52) return AIM_HI_EDGE;
		if (r < 55) return AIM_LO_FAR;
		if (r < 58) return AIM_HI_FAR;
		if (r < 88) return AIM_CENTER;
		if (r < 96) return AIM_ANY;
		if (r < 98) return AIM_MIN;
		return AIM_MAX;
	endfunction

	function automatic void set_idling(int mode);
		case (mode)
			0: begin
				send_idle_pct = 26;
				recv_idle_pct = 59;
			end
			1: begin
				send_idle_pct = 59;
				recv_idle_pct = 26;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endfunction

	// Entered and left at a falling edge; valid stays high for a following transaction.
	task automatic send_position(input pos_t p);
		if ($urandom_range(99) < send_idle_pct) begin
			pos_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		pos_valid <= 1'b1;
		pos <= p;
		@(posedge clk);
		while (pos_stall) @(posedge clk);
		sb.note_position(p);
		@(negedge clk);
	endtask

	task automatic send_aimed(input aim_t ax, input aim_t ay, input aim_t az);
		pos_t p;
		longint t;
		t = sb.reach();
		p.pos_x = aim_coord(ax, sb.box_lo[0], sb.box_hi[0], t);
		p.pos_y = aim_coord(ay, sb.box_lo[1], sb.box_hi[1], t);
		p.pos_z = aim_coord(az, sb.box_lo[2], sb.box_hi[2], t);
		send_position(p);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_register(idx, data);
		@(negedge clk);
	endtask

	task automatic wait_drained(input int extra);
		while (sb.pending() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	initial begin : result_sink
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				res_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				sb.check_result(res);
			end
			if ((res_valid && !res_stall) || (pos_valid && !pos_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no transaction for %0d cycles, %0d results outstanding",
						$time, quiet_cycles, sb.pending());
					$display("[local_map_box_shifter_core] ERROR");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		pos_t p;
		logic [CFG_DATA_W-1:0] cube_set [PHASES];
		logic [CFG_DATA_W-1:0] det_set [PHASES];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pos_valid = 1'b0;
		pos = '0;
		cube_set = '{24'd256000, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd3000, 24'd0};
		det_set = '{24'd25600, 24'd0, 24'hFFFFFF, 24'd0, 24'h3FFFFF, 24'd400, 24'd0};
		cube_set[PHASES-1] = CFG_DATA_W'($urandom_range(24'hFFFFFF));
		det_set[PHASES-1] = CFG_DATA_W'($urandom_range(22'h3FFFFF));
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_idling(0);
		@(negedge clk);

		// Placement at the top and bottom of the range saturates the corners.
		p.pos_x = 32'h7FFF_FFFF;
		p.pos_y = 32'h8000_0000;
		p.pos_z = '0;
		send_position(p);
		send_aimed(AIM_CENTER, AIM_CENTER, AIM_CENTER);
		send_aimed(AIM_HI_NEAR, AIM_LO_NEAR, AIM_CENTER);
		send_aimed(AIM_LO_EDGE, AIM_CENTER, AIM_CENTER);
		send_aimed(AIM_LO_FAR, AIM_CENTER, AIM_CENTER);
		send_aimed(AIM_CENTER, AIM_HI_EDGE, AIM_CENTER);
		send_aimed(AIM_CENTER, AIM_HI_FAR, AIM_CENTER);
		send_aimed(AIM_CENTER, AIM_CENTER, AIM_LO_NEAR);
		send_aimed(AIM_CENTER, AIM_CENTER, AIM_HI_NEAR);
		send_aimed(AIM_LO_NEAR, AIM_HI_NEAR, AIM_LO_NEAR);
		send_aimed(AIM_HI_NEAR, AIM_HI_NEAR, AIM_HI_NEAR);
		send_aimed(AIM_LO_EDGE, AIM_HI_EDGE, AIM_LO_FAR);
		send_aimed(AIM_MAX, AIM_MAX, AIM_MAX);
		send_aimed(AIM_MIN, AIM_MIN, AIM_MIN);
		send_aimed(AIM_ANY, AIM_ANY, AIM_ANY);
		send_aimed(AIM_ANY, AIM_ANY, AIM_ANY);
		send_aimed(AIM_LO_NEAR, AIM_LO_NEAR, AIM_LO_NEAR);

		for (int ph = 0; ph < PHASES; ph++) begin
			pos_valid <= 1'b0;
			wait_drained(SETTLE_CYCLES);
			write_register(CFG_CUBE_SIDE, cube_set[ph]);
			write_register(CFG_DETECT_RANGE, det_set[ph]);
			if (ph == 3) begin
				write_register(CFG_UNMAPPED_A, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
				write_register(CFG_UNMAPPED_B, 24'hFFFFFF);
			end
			cfg_we <= 1'b0;
			@(negedge clk);
			set_idling(ph % 3);
			if (ph == 2) begin
				hold_request = 1'b1;
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				send_aimed(random_aim(), random_aim(), random_aim());
			end
		end

		pos_valid <= 1'b0;
		wait_drained(TAIL_CYCLES);
		$display("Sent %0d positions over %0d register writes; checked %0d results.",
			sb.positions, sb.writes, sb.results);
		$display("Boxes placed %0d, unchanged %0d, moved %0d, removal slabs %0d.",
			sb.placed_cnt, sb.keep_cnt, sb.moved_cnt, sb.slab_cnt);
		if (sb.errors == 0) begin
			$display("[local_map_box_shifter_core] OK");
		end else begin
			$display("[local_map_box_shifter_core] ERROR");
		end
		$finish;
	end

endmodule
